FILE: sv/assert_macros.svh
// Assertion macros used by the port-level checker.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication: cons must hold in the same cycle as ante
`define SVT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted table check failed");

// next-cycle implication: cons must hold in the cycle after ante
`define SVT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted table check failed");

`endif

FILE: sv/svt_pkg.sv
// Shared types and constants for the sorted value table.
// No dependencies; used by every module of the block.
package svt_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    localparam logic [2:0] OP_INSERT       = 3'd0;
    localparam logic [2:0] OP_REMOVE_VALUE = 3'd1;
    localparam logic [2:0] OP_REMOVE_INDEX = 3'd2;
    localparam logic [2:0] OP_CONTAINS     = 3'd3;
    localparam logic [2:0] OP_READ_INDEX   = 3'd4;
    localparam logic [2:0] OP_INDEX_OF     = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic signed [DATA_W-1:0] READ_INVALID = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [2:0]                operation;
        logic signed [DATA_W-1:0]  value_in;
        logic [INDEX_W-1:0]        index_in;
    } svt_req_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [DATA_W-1:0]  value_out;
        logic [INDEX_W-1:0]        position_out;
        logic [COUNT_W-1:0]        count_out;
    } svt_rsp_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic       eval;
        logic       upd;
        logic [2:0] op;
        logic       found;
        logic       idx_ok;
        logic       full;
    } svt_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_UPD
    } svt_state_t;

endpackage

FILE: sv/svt_cell.sv
// One storage cell of the sorted table: holds one entry and its compare flags.
// Depends on svt_pkg; instantiated in a row by sorted_value_table.
module svt_cell
    import svt_pkg::*;
#(
    parameter int CNT_W = 7
)
(
    input  logic                      clk,
    input  logic [CNT_W-1:0]          pos,
    input  logic [CNT_W-1:0]          count,
    input  logic signed [DATA_W-1:0]  value,
    input  logic [INDEX_W-1:0]        index,
    input  svt_ctl_t                  ctl,
    input  logic                      prev_gt,
    input  logic                      prev_ge,
    input  logic signed [DATA_W-1:0]  prev_entry,
    input  logic signed [DATA_W-1:0]  next_entry,
    output logic signed [DATA_W-1:0]  entry,
    output logic                      gt,
    output logic                      ge,
    output logic                      hit,
    output logic                      at_idx
);

    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    logic signed [DATA_W-1:0] entry_reg, entry_next;
    logic gt_reg, ge_reg, eq_reg, at_idx_reg, from_idx_reg;
    logic occ;
    logic [CMP_W-1:0] pos_x, idx_x;

    assign occ   = pos < count;
    assign pos_x = CMP_W'(pos);
    assign idx_x = CMP_W'(index);

    always_ff @(posedge clk)
    begin
        if (ctl.eval)
        begin
            gt_reg       <= occ && (entry_reg >  value);
            ge_reg       <= occ && (entry_reg >= value);
            eq_reg       <= occ && (entry_reg == value);
            at_idx_reg   <= pos_x == idx_x;
            from_idx_reg <= pos_x >= idx_x;
        end
        entry_reg <= entry_next;
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.upd)
        begin
            case (ctl.op)
                OP_INSERT:
                begin
                    if (!ctl.full)
                    begin
                        if (prev_ge && !ge_reg)
                            entry_next = value;
                        else if (!prev_ge)
                            entry_next = prev_entry;
                    end
                end
                OP_REMOVE_VALUE:
                begin
                    if (ctl.found && !gt_reg)
                        entry_next = next_entry;
                end
                OP_REMOVE_INDEX:
                begin
                    if (ctl.idx_ok && from_idx_reg)
                        entry_next = next_entry;
                end
                default:
                begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    // first equal entry sits right after the last greater one
    assign hit    = prev_gt && !gt_reg && eq_reg;
    assign entry  = entry_reg;
    assign gt     = gt_reg;
    assign ge     = ge_reg;
    assign at_idx = at_idx_reg;

endmodule

FILE: sv/sorted_value_table.sv
// Sorted value table: up to CAPACITY signed 32-bit values kept largest first
// in a row of cells, each comparing its entry with the request in parallel.
// A request is taken when start is high and busy is low; busy then stays high
// through the compare step and then the shift/update step, and the result
// appears with done for exactly one cycle, once the update step is over. A new
// request may be issued in that same cycle; no new request is taken while busy
// is high, so requests never overlap in the cell row. The result cannot be held
// off: capture it whenever done is high. Equal values are stored next to each
// other; index of returns the first of them.
module sorted_value_table
    import svt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  svt_req_t  request,
    output logic      done,
    output svt_rsp_t  result
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int CNT7_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    svt_state_t state_reg, state_next;
    svt_req_t   req_reg;
    svt_rsp_t   rsp_reg, rsp_next;
    logic       done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;

    svt_ctl_t ctl;
    logic signed [DATA_W-1:0] entry_w [CAPACITY];
    logic [CAPACITY-1:0] gt_w, ge_w, hit_w, at_idx_w;

    logic found, idx_ok, full;
    logic [CMP_W-1:0] pos_acc;
    logic signed [DATA_W-1:0] read_val;
    logic [CNT7_W-1:0] count_x;

    assign full   = count_reg >= CNT_W'(CAPACITY);
    assign idx_ok = CMP_W'(req_reg.index_in) < CMP_W'(count_reg);
    assign found  = |hit_w;

    assign ctl.eval   = (state_reg == S_EVAL);
    assign ctl.upd    = (state_reg == S_UPD);
    assign ctl.op     = req_reg.operation;
    assign ctl.found  = found;
    assign ctl.idx_ok = idx_ok;
    assign ctl.full   = full;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic                     p_gt, p_ge;
            logic signed [DATA_W-1:0] p_entry, n_entry;

            if (g == 0)
            begin : g_first
                assign p_gt    = 1'b1;
                assign p_ge    = 1'b1;
                assign p_entry = req_reg.value_in;
            end
            else
            begin : g_mid
                assign p_gt    = gt_w[g-1];
                assign p_ge    = ge_w[g-1];
                assign p_entry = entry_w[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign n_entry = entry_w[g];
            end
            else
            begin : g_inner
                assign n_entry = entry_w[g+1];
            end

            svt_cell #(
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .pos        (CNT_W'(g)),
                .count      (count_reg),
                .value      (req_reg.value_in),
                .index      (req_reg.index_in),
                .ctl        (ctl),
                .prev_gt    (p_gt),
                .prev_ge    (p_ge),
                .prev_entry (p_entry),
                .next_entry (n_entry),
                .entry      (entry_w[g]),
                .gt         (gt_w[g]),
                .ge         (ge_w[g]),
                .hit        (hit_w[g]),
                .at_idx     (at_idx_w[g])
            );
        end
    endgenerate

    // at most one hit and one index match, so plain OR picks them out
    always_comb
    begin
        pos_acc  = '0;
        read_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hit_w[i])
                pos_acc = pos_acc | CMP_W'(i);
            if (at_idx_w[i])
                read_val = read_val | entry_w[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            req_reg <= request;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        count_x    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                state_next            = S_IDLE;
                done_next             = 1'b1;
                rsp_next.status       = ST_MISS;
                rsp_next.value_out    = '0;
                rsp_next.position_out = '0;
                case (req_reg.operation)
                    OP_INSERT:
                    begin
                        if (full)
                            rsp_next.status = ST_FULL;
                        else
                        begin
                            rsp_next.status = ST_OK;
                            count_next      = count_reg + CNT_W'(1);
                        end
                    end
                    OP_REMOVE_VALUE:
                    begin
                        if (found)
                        begin
                            rsp_next.status = ST_OK;
                            count_next      = count_reg - CNT_W'(1);
                        end
                    end
                    OP_REMOVE_INDEX:
                    begin
                        if (idx_ok)
                        begin
                            rsp_next.status = ST_OK;
                            count_next      = count_reg - CNT_W'(1);
                        end
                    end
                    OP_CONTAINS:
                    begin
                        if (found)
                            rsp_next.status = ST_OK;
                    end
                    OP_READ_INDEX:
                    begin
                        if (idx_ok)
                        begin
                            rsp_next.status    = ST_OK;
                            rsp_next.value_out = read_val;
                        end
                        else
                            rsp_next.value_out = READ_INVALID;
                    end
                    OP_INDEX_OF:
                    begin
                        if (found)
                        begin
                            rsp_next.status       = ST_OK;
                            rsp_next.position_out = pos_acc[INDEX_W-1:0];
                        end
                    end
                    default:
                    begin
                        rsp_next.status = ST_MISS;
                    end
                endcase
                count_x            = CNT7_W'(count_next);
                rsp_next.count_out = count_x[COUNT_W-1:0];
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

FILE: sv/svt_checker.sv
// Port-level checker for the sorted value table, bound to the top level.
// Depends on svt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module svt_checker
    import svt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  logic      done,
    input  svt_rsp_t  result
);

    // a result is only shown once the block is free again
    `SVT_ASSERT_IMP(a_done_not_busy, done, !busy)
    // a taken request makes the block busy
    `SVT_ASSERT_NXT(a_take_busy, start && !busy, busy)
    // a taken request is answered by done
    `SVT_ASSERT_IMP(a_latency, start && !busy, ##3 done)
    // full only comes with a zero read value and position
    `SVT_ASSERT_IMP(a_full_clean, done && result.status == ST_FULL,
        result.value_out == '0 && result.position_out == '0)

endmodule

bind sorted_value_table svt_checker u_svt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

FILE: tb/sv/svt_check_pkg.sv
`timescale 1ns / 1ps
// Expected-response tracking for the sorted value table testbench.
// Depends on svt_pkg for the request/response types and operation codes.
package svt_check_pkg;
    import svt_pkg::*;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    class sorted_list_tracker;
        logic signed [DATA_W-1:0] vals [DEFAULT_CAPACITY];
        int       fill;
        svt_rsp_t expected_q[$];
        int       errors;
        int       requests;
        int       responses;
        int       full_hits;
        int       misses;
        int       peak;

        function new();
            foreach (vals[i]) vals[i] = '0;
            fill      = 0;
            errors    = 0;
            requests  = 0;
            responses = 0;
            full_hits = 0;
            misses    = 0;
            peak      = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // first position holding v, or fill when absent
        function int first_of(logic signed [DATA_W-1:0] v);
            for (int i = 0; i < fill; i++)
                if (vals[i] == v) return i;
            return fill;
        endfunction

        function void drop(int pos);
            for (int i = pos; i + 1 < fill; i++) vals[i] = vals[i + 1];
            fill--;
        endfunction

        // apply one accepted request to the shadow list and queue its response
        function void take_request(svt_req_t req);
            svt_rsp_t rsp;
            int       pos;
            rsp = '0;
            rsp.status = ST_MISS;
            case (req.operation)
                OP_INSERT: begin
                    if (fill >= DEFAULT_CAPACITY) begin
                        rsp.status = ST_FULL;
                        full_hits++;
                    end
                    else begin
                        // equal values go after the existing ones
                        pos = 0;
                        while (pos < fill && vals[pos] >= req.value_in) pos++;
                        for (int i = fill; i > pos; i--) vals[i] = vals[i - 1];
                        vals[pos] = req.value_in;
                        fill++;
                        rsp.status = ST_OK;
                    end
                end
                OP_REMOVE_VALUE: begin
                    pos = first_of(req.value_in);
                    if (pos < fill) begin
                        drop(pos);
                        rsp.status = ST_OK;
                    end
                end
                OP_REMOVE_INDEX: begin
                    if (int'(req.index_in) < fill) begin
                        drop(int'(req.index_in));
                        rsp.status = ST_OK;
                    end
                end
                OP_CONTAINS: begin
                    if (first_of(req.value_in) < fill) rsp.status = ST_OK;
                end
                OP_READ_INDEX: begin
                    if (int'(req.index_in) < fill) begin
                        rsp.value_out = vals[req.index_in];
                        rsp.status    = ST_OK;
                    end
                    else begin
                        rsp.value_out = READ_INVALID;
                    end
                end
                OP_INDEX_OF: begin
                    pos = first_of(req.value_in);
                    if (pos < fill) begin
                        rsp.position_out = pos[INDEX_W-1:0];
                        rsp.status       = ST_OK;
                    end
                end
                default: ;
            endcase
            if (rsp.status == ST_MISS) misses++;
            if (fill > peak) peak = fill;
            rsp.count_out = fill[COUNT_W-1:0];
            expected_q.push_back(rsp);
            requests++;
        endfunction

        function void match_response(svt_rsp_t got);
            svt_rsp_t exp;
            responses++;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.value_out !== exp.value_out) begin
                $error("value_out: expected %0d, actual %0d", exp.value_out, got.value_out);
                errors++;
            end
            if (got.position_out !== exp.position_out) begin
                $error("position_out: expected %0d, actual %0d",
                       exp.position_out, got.position_out);
                errors++;
            end
            if (got.count_out !== exp.count_out) begin
                $error("count_out: expected %0d, actual %0d", exp.count_out, got.count_out);
                errors++;
            end
        endfunction
    endclass

endpackage

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top-level testbench for sorted_value_table: directed corner requests, then
// weighted random rounds in bursts. Depends on svt_pkg and svt_check_pkg.
module tb;
    import svt_pkg::*;
    import svt_check_pkg::*;

    localparam real HALF_PERIOD = 2.0;
    localparam int  LATENCY     = 3;
    localparam int  CYCLE_LIMIT = 100000;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    svt_req_t request = '0;
    logic     busy;
    logic     done;
    svt_rsp_t result;

    sorted_list_tracker tracker;
    int                 cycles;

    sorted_value_table u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done) tracker.match_response(result);
    end

    function automatic svt_req_t make_req(logic [2:0] op, logic signed [DATA_W-1:0] v,
                                          logic [INDEX_W-1:0] idx);
        svt_req_t req;
        req.operation = op;
        req.value_in  = v;
        req.index_in  = idx;
        return req;
    endfunction

    // mostly values that hit the list or collide with each other
    function automatic logic signed [DATA_W-1:0] rand_value();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            case ($urandom_range(3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return -1;
            endcase
        end
        if (r <= 3) return $signed($urandom_range(16)) - 8;
        if (r <= 5 && tracker.fill > 0) return tracker.vals[$urandom_range(tracker.fill - 1)];
        return $urandom;
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index();
        if (tracker.fill > 0 && $urandom_range(2) != 0)
            return INDEX_W'($urandom_range(tracker.fill - 1));
        return INDEX_W'($urandom_range(63));
    endfunction

    function automatic logic [2:0] pick_op(int ins_pct, int rem_pct);
        int r;
        r = $urandom_range(99);
        if (r < ins_pct) return OP_INSERT;
        if (r < ins_pct + rem_pct)
            return ($urandom_range(1) != 0) ? OP_REMOVE_VALUE : OP_REMOVE_INDEX;
        if (r >= 97) return ($urandom_range(1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
        case ($urandom_range(2))
            0: return OP_CONTAINS;
            1: return OP_READ_INDEX;
            default: return OP_INDEX_OF;
        endcase
    endfunction

    // hold the request until the block takes it; start stays high for the caller
    task automatic issue(input svt_req_t req);
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy) @(posedge clk);
        tracker.take_request(req);
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic run_round(input int n, input int ins_pct, input int rem_pct);
        int sent;
        int burst;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < n; i++) begin
                issue(make_req(pick_op(ins_pct, rem_pct), rand_value(), rand_index()));
                sent++;
            end
            if ($urandom_range(3) != 0) pause($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("sorted_value_table test failed");
        $finish;
    end

    initial
    begin
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, unused codes
        issue(make_req(OP_READ_INDEX, '0, 6'd0));
        issue(make_req(OP_REMOVE_INDEX, '0, 6'd0));
        issue(make_req(OP_REMOVE_VALUE, VAL_MIN, 6'd0));
        issue(make_req(OP_CONTAINS, '0, 6'd0));
        issue(make_req(OP_INDEX_OF, VAL_MAX, 6'd0));
        issue(make_req(OP_SPARE_6, -1, 6'd63));
        issue(make_req(OP_SPARE_7, '0, 6'd0));
        // extremes and a duplicate
        issue(make_req(OP_INSERT, VAL_MAX, 6'd0));
        issue(make_req(OP_INSERT, VAL_MIN, 6'd0));
        issue(make_req(OP_INSERT, '0, 6'd0));
        issue(make_req(OP_INSERT, -1, 6'd0));
        issue(make_req(OP_INSERT, '0, 6'd0));
        issue(make_req(OP_INSERT, 1, 6'd0));
        issue(make_req(OP_INDEX_OF, '0, 6'd0));
        issue(make_req(OP_CONTAINS, VAL_MIN, 6'd0));
        issue(make_req(OP_READ_INDEX, '0, 6'd0));
        issue(make_req(OP_READ_INDEX, '0, 6'd5));
        issue(make_req(OP_READ_INDEX, '0, 6'd6));
        issue(make_req(OP_READ_INDEX, '0, 6'd63));
        issue(make_req(OP_REMOVE_VALUE, '0, 6'd0));
        issue(make_req(OP_REMOVE_VALUE, 12345, 6'd0));
        issue(make_req(OP_REMOVE_INDEX, '0, 6'd4));
        issue(make_req(OP_INDEX_OF, -1, 6'd0));
        issue(make_req(OP_REMOVE_INDEX, '0, 6'd0));
        issue(make_req(OP_CONTAINS, VAL_MAX, 6'd0));
        drain();

        // fill, churn, drain down, then push past full
        run_round(100, 70, 5);
        drain();
        run_round(100, 30, 20);
        drain();
        run_round(100, 5, 60);
        drain();
        run_round(100, 85, 5);
        drain();
        repeat (LATENCY + 4) @(posedge clk);

        $display("covered %0d requests, %0d results: %0d inserts refused as full, %0d misses",
                 tracker.requests, tracker.responses, tracker.full_hits, tracker.misses);
        $display("peak occupancy %0d of %0d entries", tracker.peak, DEFAULT_CAPACITY);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("sorted_value_table test passed");
        else
            $display("sorted_value_table test failed");
        $finish;
    end

endmodule

FILE: sorted_value_table.f
+incdir+sv
sv/svt_pkg.sv
sv/svt_cell.sv
sv/sorted_value_table.sv
sv/svt_checker.sv
tb/sv/svt_check_pkg.sv
tb/sv/tb.sv
